@@ rtl/zzsag_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the helper function of the zigzag scan address generator.
package zzsag_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int DATA_WIDTH = 16;
    localparam int SIDE_W     = 7;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = 12;
    localparam int CORNER_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = IDX_W + SIDE_W;
    localparam int SQ_W       = 2 * SIDE_W;

    localparam int S_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_WIDTH + IDX_W + IDX_W + ADDR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_CORNER = CFG_IDX_W'(1);

    // Bits of the start corner register
    localparam int CORNER_RIGHT_BIT = 0;
    localparam int CORNER_TOP_BIT   = 1;

    localparam logic [SIDE_W-1:0]   SIDE_RESET    = SIDE_W'(8);
    localparam logic [CORNER_W-1:0] CORNER_RESET  = CORNER_W'(2);
    localparam logic [SIDE_W-1:0]   MIN_SIDE_V    = SIDE_W'(2);
    localparam logic [SIDE_W-1:0]   MAX_SIDE_V    = SIDE_W'(MAX_SIDE);
    localparam logic [ADDR_W-1:0]   LAST_COUNT_RESET =
        ADDR_W'(int'(SIDE_RESET) * int'(SIDE_RESET) - 1);
    localparam logic [IDX_W-1:0]    ROW_RESET =
        CORNER_RESET[CORNER_TOP_BIT] ? IDX_W'(0) : IDX_W'(int'(SIDE_RESET) - 1);
    localparam logic [IDX_W-1:0]    COL_RESET =
        CORNER_RESET[CORNER_RIGHT_BIT] ? IDX_W'(int'(SIDE_RESET) - 1) : IDX_W'(0);

    // Configuration as seen by the position tracker
    typedef struct packed {
        logic [SIDE_W-1:0]   side;        // clamped side in use
        logic [CORNER_W-1:0] corner;
        logic [ADDR_W-1:0]   last_count;  // side squared minus one
        logic                restart;     // register write this cycle
        logic [IDX_W-1:0]    start_row;
        logic [IDX_W-1:0]    start_col;
    } cfg_t;

    // One placed element between the tracker and the address stage
    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic                  last;
        logic [SIDE_W-1:0]     side;
    } place_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (s < MIN_SIDE_V) begin
            r = MIN_SIDE_V;
        end else if (s > MAX_SIDE_V) begin
            r = MAX_SIDE_V;
        end
        return r;
    endfunction

endpackage

@@ rtl/zzsag_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration registers, side clamping and start corner decode.
module zzsag_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [zzsag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zzsag_pkg::SIDE_W-1:0]     cfg_wdata,
    output zzsag_pkg::cfg_t                  cfg
);
    import zzsag_pkg::*;

    logic [SIDE_W-1:0]   side_reg, side_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic [ADDR_W-1:0]   last_count_reg, last_count_next;
    logic                restart;
    logic [SIDE_W-1:0]   n_next;
    logic [SQ_W-1:0]     sq_next;
    logic [IDX_W-1:0]    n_minus1_next;

    always_comb begin
        side_next   = side_reg;
        corner_next = corner_reg;
        restart     = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIDE_SIZE: begin
                    side_next = cfg_wdata;
                    restart   = 1'b1;
                end
                REG_START_CORNER: begin
                    corner_next = cfg_wdata[CORNER_W-1:0];
                    restart     = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_next          = clamp_side(side_next);
        sq_next         = SQ_W'(n_next) * SQ_W'(n_next);
        last_count_next = ADDR_W'(sq_next - SQ_W'(1));
        n_minus1_next   = IDX_W'(n_next - SIDE_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg       <= SIDE_RESET;
            corner_reg     <= CORNER_RESET;
            last_count_reg <= LAST_COUNT_RESET;
        end else begin
            side_reg       <= side_next;
            corner_reg     <= corner_next;
            last_count_reg <= last_count_next;
        end
    end

    always_comb begin
        cfg.side       = clamp_side(side_reg);
        cfg.corner     = corner_reg;
        cfg.last_count = last_count_reg;
        cfg.restart    = restart;
        cfg.start_row  = corner_next[CORNER_TOP_BIT] ? '0 : n_minus1_next;
        cfg.start_col  = corner_next[CORNER_RIGHT_BIT] ? n_minus1_next : '0;
    end

endmodule

@@ rtl/zzsag_position_tracker.sv @@
`timescale 1ns / 1ps
// Zigzag position state, next-place logic and the input stage register.
module zzsag_position_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  zzsag_pkg::cfg_t                  cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [zzsag_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             s1_valid,
    output zzsag_pkg::place_t                s1_place,
    input  logic                             s2_ready
);
    import zzsag_pkg::*;

    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              sign_reg, sign_next;
    logic              axis_reg, axis_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic              s1_valid_reg, s1_valid_next;
    place_t            s1_place_reg;

    logic             accept;
    logic [IDX_W-1:0] n_minus1;
    logic             row_lo, row_hi, col_lo, col_hi;
    logic             top, right;
    logic             row_up, col_up;
    logic             off_square, at_corner, edge_col;
    logic             last;

    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        n_minus1  = IDX_W'(cfg.side - SIDE_W'(1));
        row_lo    = (row_reg == '0);
        row_hi    = (row_reg == n_minus1);
        col_lo    = (col_reg == '0);
        col_hi    = (col_reg == n_minus1);
        top       = cfg.corner[CORNER_TOP_BIT];
        right     = cfg.corner[CORNER_RIGHT_BIT];
        // Diagonal direction: sign 0 moves away from the start corner along the columns and toward it along the rows.
        row_up    = sign_reg ? top : !top;
        col_up    = sign_reg ? right : !right;
        off_square = (row_up ? row_hi : row_lo) || (col_up ? col_hi : col_lo);
        at_corner = (row_lo || row_hi) && (col_lo || col_hi);
        edge_col  = axis_reg ^ at_corner;
        last      = (count_reg == cfg.last_count);

        row_next      = row_reg;
        col_next      = col_reg;
        sign_next     = sign_reg;
        axis_next     = axis_reg;
        count_next    = count_reg;
        s1_valid_next = s1_valid_reg;

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s2_ready) begin
            s1_valid_next = 1'b0;
        end

        priority if (cfg.restart || (accept && last)) begin
            row_next   = cfg.start_row;
            col_next   = cfg.start_col;
            sign_next  = 1'b0;
            axis_next  = 1'b0;
            count_next = '0;
        end else if (accept) begin
            count_next = count_reg + ADDR_W'(1);
            if (off_square) begin
                if (edge_col) begin
                    col_next = right ? col_reg - IDX_W'(1) : col_reg + IDX_W'(1);
                end else begin
                    row_next = top ? row_reg + IDX_W'(1) : row_reg - IDX_W'(1);
                end
                sign_next = !sign_reg;
                if (!at_corner) begin
                    axis_next = !axis_reg;
                end
            end else begin
                row_next = row_up ? row_reg + IDX_W'(1) : row_reg - IDX_W'(1);
                col_next = col_up ? col_reg + IDX_W'(1) : col_reg - IDX_W'(1);
            end
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= ROW_RESET;
            col_reg      <= COL_RESET;
            sign_reg     <= 1'b0;
            axis_reg     <= 1'b0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            sign_reg     <= sign_next;
            axis_reg     <= axis_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_place_reg.value <= s_tdata[DATA_WIDTH-1:0];
            s1_place_reg.row   <= row_reg;
            s1_place_reg.col   <= col_reg;
            s1_place_reg.last  <= last;
            s1_place_reg.side  <= cfg.side;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_place = s1_place_reg;

endmodule

@@ rtl/zzsag_address_stage.sv @@
`timescale 1ns / 1ps
// Row-major address multiply-add and the result register.
module zzsag_address_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s1_valid,
    input  zzsag_pkg::place_t                s1_place,
    output logic                             s2_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [zzsag_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import zzsag_pkg::*;

    logic [PROD_W-1:0]    prod;
    logic [ADDR_W-1:0]    addr;
    logic                 load;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    assign s2_ready = !m_valid_reg || m_tready;
    assign load     = s1_valid && s2_ready;

    always_comb begin
        prod = PROD_W'(s1_place.row) * PROD_W'(s1_place.side);
        addr = ADDR_W'(prod) + ADDR_W'(s1_place.col);
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= M_TDATA_W'({addr, s1_place.col, s1_place.row, s1_place.value});
            m_last_reg <= s1_place.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/zigzag_scan_address_generator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the zigzag scan address generator.
//
//  Channel   Direction  Signals                        Contents
//  cfg       in         cfg_wr_en, cfg_index, cfg_wdata  0: side_size, 1: start_corner
//  s_        in         s_tvalid, s_tready, s_tdata      element_value
//  m_        out        m_tvalid, m_tready, m_tdata,     value, row, column, address;
//                       m_tlast                          tlast marks the final element
//
// One request is taken every clock cycle while s_tready is high. The position tracker
// registers the request with its place on acceptance; the address multiply-add between that
// register and the result register forms the address, and the result register loads it,
// raising m_tvalid, once it is free.
// Reset is synchronous and active low; it restores side 8 and the top-left start
// corner, and the scan starts from that corner.
// Stalls on the result side propagate back through both stages to s_tready, so two
// requests can be held while m_tready is low.
// Any write to a known register index restarts the scan at the new start corner.
module zigzag_scan_address_generator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [zzsag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zzsag_pkg::SIDE_W-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: [15:0] element_value
    input  logic [zzsag_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: [15:0] element_value_out, [21:16] row_index, [27:22] column_index,
    //          [39:28] linear_address
    output logic [zzsag_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);
    import zzsag_pkg::*;

    cfg_t   cfg;
    logic   s1_valid;
    place_t s1_place;
    logic   s2_ready;

    // Configuration registers; the clamped side and start position are decoded here.
    zzsag_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Walks the zigzag path and captures each element with its place.
    zzsag_position_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s1_valid (s1_valid),
        .s1_place (s1_place),
        .s2_ready (s2_ready)
    );

    // Forms the row-major address and holds the result until it is taken.
    zzsag_address_stage u_addr_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid),
        .s1_place (s1_place),
        .s2_ready (s2_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A captured place always lies inside the square.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid |-> (s1_place.row < IDX_W'(s1_place.side - SIDE_W'(1)) ||
                      s1_place.row == IDX_W'(s1_place.side - SIDE_W'(1))) &&
                     (s1_place.col < IDX_W'(s1_place.side - SIDE_W'(1)) ||
                      s1_place.col == IDX_W'(s1_place.side - SIDE_W'(1))))
        else $error("zigzag place outside the square");

    // The final element of a scan always lands on a corner.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid && s1_place.last |->
            (s1_place.row == '0 || s1_place.row == IDX_W'(s1_place.side - SIDE_W'(1))) &&
            (s1_place.col == '0 || s1_place.col == IDX_W'(s1_place.side - SIDE_W'(1))))
        else $error("last element not on a corner");

    // A stalled first stage keeps its element until the result register frees.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid && !s2_ready |=> s1_valid && $stable(s1_place))
        else $error("stalled element lost in the first stage");

endmodule
